// ===== rtl/iee_pkg.sv =====
package iee_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned DivCntW    = $clog2(ValueWidth);

  localparam logic [7:0] ChAdd  = 8'h2B;
  localparam logic [7:0] ChSub  = 8'h2D;
  localparam logic [7:0] ChMul  = 8'h2A;
  localparam logic [7:0] ChDiv  = 8'h2F;
  localparam logic [7:0] ChLpar = 8'h28;
  localparam logic [7:0] ChRpar = 8'h29;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StDivZero  = 2'd1;
  localparam logic [1:0] StMalform  = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LPAR = 3'd5
  } op_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [1:0]                   status;
  } out_t;

  // 2: multiplicative, 1: additive, 0: anything else
  function automatic logic [1:0] prec(op_e op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    else if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    return p;
  endfunction

endpackage

// ===== rtl/iee_ram.sv =====
module iee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/infix_expression_evaluator.sv =====
// Channel | Direction | Handshake                 | Payload
// request | in        | in_valid_i / in_stall_o   | in_req_i  (char_code, last)
// result  | out       | out_valid_o / out_stall_i | out_rsp_o (value, status)
//
// One character at a time; the block stalls input while it works.
// A digit or '(' is pushed at once; each operator applied reads the stack RAMs,
// then uses the ALU, or the bit-serial divider for a division.
// The final character adds a reduce pass, a read of the value stack and the output.
// Reset clears counts, error and control; stack RAM contents are not cleared.
// A stalled result holds until taken; no new request is accepted meanwhile.
module infix_expression_evaluator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  iee_pkg::in_t   in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output iee_pkg::out_t  out_rsp_o
);
  import iee_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DONE  = 11'b00000000010,
    S_RED   = 11'b00000000100,
    S_OPCHK = 11'b00000001000,
    S_VRHS  = 11'b00000010000,
    S_VLHS  = 11'b00000100000,
    S_ALU   = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_POST  = 11'b00100000000,
    S_FRD   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] ocnt_q, ocnt_d, vcnt_q, vcnt_d;
  logic [1:0] err_q, err_d;
  op_e cop_q, cop_d, top_q, top_d, aop_q, aop_d;
  logic rpar_q, rpar_d, fin_q, fin_d, last_q, last_d, hip_q, hip_d, neg_q, neg_d;
  logic [ValueWidth-1:0] lhs_q, lhs_d, rhs_q, rhs_d, rem_q, rem_d, quo_q, quo_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic out_valid_q, out_valid_d;
  out_t rsp_q, rsp_d;

  logic o_we, v_we;
  logic [AddrW-1:0] o_waddr, o_raddr, v_waddr, v_raddr;
  logic [2:0] o_wdata, o_rdata;
  logic [ValueWidth-1:0] v_wdata, v_rdata;

  iee_ram #(.Width(3), .Depth(StackDepth)) u_op_ram (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .raddr_i(o_raddr), .rdata_o(o_rdata)
  );

  iee_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_val_ram (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  logic [7:0] ch;
  logic is_digit;
  op_e top_rd;
  logic [1:0] top_prec;
  logic [ValueWidth:0] rem_sh, diff;
  logic [ValueWidth-1:0] quo_fin, lhs_mag, rhs_mag;

  assign ch       = in_req_i.char_code;
  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign top_rd   = op_e'(o_rdata);
  assign top_prec = prec(top_rd);
  assign rem_sh   = {rem_q, quo_q[ValueWidth-1]};
  assign diff     = rem_sh - {1'b0, rhs_q};
  assign quo_fin  = neg_q ? (~quo_d) + 1'b1 : quo_d;
  assign lhs_mag  = lhs_q[ValueWidth-1] ? (~lhs_q) + 1'b1 : lhs_q;
  assign rhs_mag  = rhs_q[ValueWidth-1] ? (~rhs_q) + 1'b1 : rhs_q;

  always_comb begin
    state_d = state_q;
    ocnt_d = ocnt_q; vcnt_d = vcnt_q; err_d = err_q;
    cop_d = cop_q; top_d = top_q; aop_d = aop_q;
    rpar_d = rpar_q; fin_d = fin_q; last_d = last_q; hip_d = hip_q; neg_d = neg_q;
    lhs_d = lhs_q; rhs_d = rhs_q; rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q;
    out_valid_d = out_valid_q; rsp_d = rsp_q;
    o_we = 1'b0; o_waddr = ocnt_q[AddrW-1:0]; o_wdata = 3'(OP_LPAR);
    o_raddr = '0;
    v_we = 1'b0; v_waddr = vcnt_q[AddrW-1:0]; v_wdata = '0;
    v_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = in_req_i.last;
          fin_d = 1'b0;
          rpar_d = 1'b0;
          state_d = S_DONE;
          if (err_q == StOk) begin
            if (is_digit) begin
              if (vcnt_q >= CntW'(StackDepth)) err_d = StOverflow;
              else begin
                v_we = 1'b1;
                v_wdata = ValueWidth'(ch - ChZero);
                vcnt_d = vcnt_q + 1'b1;
              end
            end else if (ch == ChLpar) begin
              if (ocnt_q >= CntW'(StackDepth)) err_d = StOverflow;
              else begin
                o_we = 1'b1;
                ocnt_d = ocnt_q + 1'b1;
              end
            end else if (ch == ChMul || ch == ChDiv) begin
              cop_d = (ch == ChMul) ? OP_MUL : OP_DIV;
              hip_d = 1'b1;
              state_d = S_RED;
            end else if (ch == ChAdd || ch == ChSub || ch == ChRpar) begin
              cop_d = (ch == ChAdd) ? OP_ADD : OP_SUB;
              rpar_d = (ch == ChRpar);
              hip_d = 1'b0;
              state_d = S_RED;
            end
          end
        end
      end
      S_DONE: begin
        if (!last_q) state_d = S_IDLE;
        else if (err_q == StOk) begin
          fin_d = 1'b1;
          hip_d = 1'b0;
          state_d = S_RED;
        end else state_d = S_FRD;
      end
      S_RED: begin
        top_d = OP_NONE;
        if (err_q != StOk || ocnt_q == '0) state_d = S_POST;
        else begin
          o_raddr = AddrW'(ocnt_q - 1'b1);
          state_d = S_OPCHK;
        end
      end
      S_OPCHK: begin
        top_d = top_rd;
        if (top_prec == 2'd0 || (hip_q && top_prec != 2'd2)) state_d = S_POST;
        else begin
          ocnt_d = ocnt_q - 1'b1;
          aop_d = top_rd;
          if (vcnt_q < CntW'(2)) begin
            err_d = StMalform;
            state_d = S_RED;
          end else begin
            v_raddr = AddrW'(vcnt_q - 1'b1);
            state_d = S_VRHS;
          end
        end
      end
      S_VRHS: begin
        rhs_d = v_rdata;
        v_raddr = AddrW'(vcnt_q - CntW'(2));
        state_d = S_VLHS;
      end
      S_VLHS: begin
        lhs_d = v_rdata;
        state_d = S_ALU;
      end
      S_ALU: begin
        if (aop_q == OP_DIV) begin
          if (rhs_q == '0) begin
            err_d = StDivZero;
            state_d = S_RED;
          end else begin
            // start the restoring divider on magnitudes
            neg_d = lhs_q[ValueWidth-1] ^ rhs_q[ValueWidth-1];
            quo_d = lhs_mag;
            rhs_d = rhs_mag;
            rem_d = '0;
            dcnt_d = '0;
            state_d = S_DIV;
          end
        end else begin
          v_we = 1'b1;
          v_waddr = AddrW'(vcnt_q - CntW'(2));
          unique case (aop_q)
            OP_ADD:  v_wdata = lhs_q + rhs_q;
            OP_SUB:  v_wdata = lhs_q - rhs_q;
            default: v_wdata = lhs_q * rhs_q;
          endcase
          vcnt_d = vcnt_q - 1'b1;
          state_d = S_RED;
        end
      end
      S_DIV: begin
        if (!diff[ValueWidth]) begin
          rem_d = diff[ValueWidth-1:0];
          quo_d = {quo_q[ValueWidth-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[ValueWidth-1:0];
          quo_d = {quo_q[ValueWidth-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DivCntW'(ValueWidth - 1)) begin
          v_we = 1'b1;
          v_waddr = AddrW'(vcnt_q - CntW'(2));
          v_wdata = quo_fin;
          vcnt_d = vcnt_q - 1'b1;
          state_d = S_RED;
        end
      end
      S_POST: begin
        if (fin_q) begin
          if (err_q == StOk && (ocnt_q != '0 || vcnt_q != CntW'(1))) err_d = StMalform;
          state_d = S_FRD;
        end else begin
          state_d = S_DONE;
          if (err_q == StOk) begin
            if (rpar_q) begin
              if (ocnt_q != '0 && top_q == OP_LPAR) ocnt_d = ocnt_q - 1'b1;
              else err_d = StMalform;
            end else if (ocnt_q >= CntW'(StackDepth)) err_d = StOverflow;
            else begin
              o_we = 1'b1;
              o_wdata = 3'(cop_q);
              ocnt_d = ocnt_q + 1'b1;
            end
          end
        end
      end
      S_FRD: begin
        rsp_d.value = (err_q == StOk) ? v_rdata : '0;
        rsp_d.status = err_q;
        out_valid_d = 1'b1;
        ocnt_d = '0;
        vcnt_d = '0;
        err_d = StOk;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ocnt_q <= '0;
      vcnt_q <= '0;
      err_q <= StOk;
      out_valid_q <= 1'b0;
      fin_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ocnt_q <= ocnt_d;
      vcnt_q <= vcnt_d;
      err_q <= err_d;
      out_valid_q <= out_valid_d;
      fin_q <= fin_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cop_q <= cop_d; top_q <= top_d; aop_q <= aop_d;
    rpar_q <= rpar_d; hip_q <= hip_d; neg_q <= neg_d;
    lhs_q <= lhs_d; rhs_q <= rhs_d; rem_q <= rem_d; quo_q <= quo_d;
    dcnt_q <= dcnt_d; rsp_q <= rsp_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== rtl/iee_checker.sv =====
module iee_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_o,
  input  iee_pkg::in_t   in_req_i,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  iee_pkg::out_t  out_rsp_o
);
  import iee_pkg::*;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken without going busy");

  a_no_req_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request open while result pending");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != StOk |-> out_rsp_o.value == '0)
    else $error("non-zero value with error status");

  a_result_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_req_i.last |=> !out_valid_o)
    else $error("result without final character");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);
